>>> src/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants of the packed timestamp decoder pipeline.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // divide steps done in one pipeline stage, and where the divider starts
  localparam int DivBits        = 32;
  localparam int StepsPerStage  = 2;
  localparam int DivFirst       = 3;
  localparam int NumStages      = DivFirst + DivBits / StepsPerStage;

  localparam logic [12:0] YearOffset  = 13'd6800;  // 2000 + 4800
  localparam logic [21:0] JdnBias     = 22'd32126; // 32075 + 3*69/4
  localparam logic [19:0] UsPerSecond = 20'd1000000;
  localparam logic [31:0] FracMax     = 32'hFFFF_FFFF;
  localparam logic [0:0]  RegClockCount = 1'b0;

  // one item as it travels down the pipeline
  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        kind;
    logic        bad;
    logic [11:0] ticks;
    logic [21:0] term_a;
    logic [8:0]  term_b;
    logic [21:0] jdn;
    logic [16:0] hms;
    logic [38:0] secs;
    logic [31:0] prod;
    logic        ovf;
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
  } item_t;

  // divider working set
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
  } div_t;

  // 367*(m-2+12k)/12 for every month code
  function automatic logic [8:0] month_term(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd305;
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      4'd13:   r = 9'd336;
      4'd14:   r = 9'd367;
      default: r = 9'd397;
    endcase
    return r;
  endfunction

endpackage

>>> src/ptd_decode.sv
// ----------------------------------------------------------------------------
// ptd_decode
// Hex character decode, field unpack and tick product of one beat.
// ----------------------------------------------------------------------------
module ptd_decode import ptd_pkg::*; (
  input  logic [63:0] date_chars,
  input  logic [23:0] tick_chars,
  output item_t       item
);

  logic [3:0]  nib [11];
  logic [10:0] bad_ch;
  logic [7:0]  ch  [11];
  logic [3:0]  yf;

  // ascii to nibble, bad characters read as zero
  always_comb begin
    for (int i = 0; i < 8; i++) ch[i] = date_chars[56 - 8*i +: 8];
    for (int i = 0; i < 3; i++) ch[8+i] = tick_chars[16 - 8*i +: 8];
    for (int i = 0; i < 11; i++) begin
      bad_ch[i] = 1'b0;
      if (ch[i] >= 8'h30 && ch[i] <= 8'h39)      nib[i] = ch[i][3:0];
      else if (ch[i] >= 8'h61 && ch[i] <= 8'h66) nib[i] = ch[i][3:0] + 4'd9;
      else if (ch[i] >= 8'h41 && ch[i] <= 8'h46) nib[i] = ch[i][3:0] + 4'd9;
      else begin
        nib[i]    = 4'd0;
        bad_ch[i] = 1'b1;
      end
    end
  end

  // field unpack
  always_comb begin
    item        = '0;
    yf          = {nib[0][1:0], nib[1][3:2]};
    item.year   = (yf < 4'd9) ? 11'd2016 + {7'd0, yf} : 11'd2000 + {7'd0, yf};
    item.month  = {nib[1][1:0], nib[2][3:2]};
    item.day    = {nib[2][1:0], nib[3][3:1]};
    item.hour   = {nib[3][0], nib[4]};
    item.minute = {nib[5], nib[6][3:2]};
    item.second = {nib[6][1:0], nib[7]};
    item.kind   = nib[0][3];
    item.bad    = |bad_ch;
    item.ticks  = {nib[8], nib[9], nib[10]};
    item.prod   = 32'({20'd0, item.ticks} * {12'd0, UsPerSecond});
  end

endmodule

>>> src/ptd_div_step.sv
// ----------------------------------------------------------------------------
// ptd_div_step
// Restoring division steps of one pipeline stage.
// ----------------------------------------------------------------------------
module ptd_div_step import ptd_pkg::*; (
  input  div_t        din,
  input  logic [31:0] divisor,
  output div_t        dout
);

  logic [32:0] trial;

  // one quotient bit per step, remainder stays below the divisor
  always_comb begin
    dout  = din;
    trial = '0;
    for (int i = 0; i < StepsPerStage; i++) begin
      trial    = {dout.rem, dout.low[31]};
      dout.low = {dout.low[30:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial    = trial - {1'b0, divisor};
        dout.quo = {dout.quo[30:0], 1'b1};
      end else begin
        dout.quo = {dout.quo[30:0], 1'b0};
      end
      dout.rem = trial[31:0];
    end
  end

endmodule

>>> src/packed_timestamp_decoder_core.sv
// ----------------------------------------------------------------------------
// packed_timestamp_decoder_core
// Packed timestamp decoder: calendar fields, julian day, seconds and tick
// fraction in microseconds.
//
//  channel   signals                                  direction
//  item      item_valid, item_stall, date/tick chars  in
//  result    result_valid, result_stall, fields       out
//  config    psel penable pwrite paddr pwdata prdata  apb
//
// one beat per cycle while result_stall is low, through NumStages pipeline stages set by the
// 32-bit restoring divider at two quotient bits per stage.
// each stage holds its beat under stall and takes a new one when empty or
// when the stage ahead moves, so bubbles collapse.
// synchronous reset clears the valid bits and sets clock_count to 4194304.
// ----------------------------------------------------------------------------
module packed_timestamp_decoder_core import ptd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [63:0] date_chars,
  input  logic [23:0] tick_chars,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [10:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour_value,
  output logic [5:0]  minute_value,
  output logic [5:0]  second_value,
  output logic [21:0] julian_day_number,
  output logic [38:0] absolute_seconds,
  output logic [11:0] tick_count,
  output logic [31:0] fraction_us,
  output logic        channel_kind,
  output logic        bad_digit
);

  logic [31:0] clock_count;
  item_t       st   [NumStages];
  item_t       nxt  [NumStages];
  logic        vld  [NumStages];
  logic        en   [NumStages + 1];

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegClockCount) ? clock_count : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_count <= 32'd4194304;
    end else if (psel && penable && pwrite && paddr[2] == RegClockCount) begin
      clock_count <= pwdata;
    end
  end

  // stage enables from the output back
  always_comb begin
    en[NumStages] = !result_stall;
    for (int s = NumStages - 1; s >= 0; s--) en[s] = !vld[s] || en[s+1];
  end
  assign item_stall = !en[0];

  // decode stage
  ptd_decode u_decode (
    .date_chars (date_chars),
    .tick_chars (tick_chars),
    .item       (nxt[0])
  );

  // later stages
  for (genvar s = 1; s < NumStages; s++) begin : g_stage
    if (s == 1) begin : g_terms
      logic        k;
      logic [12:0] yk;
      always_comb begin
        nxt[s]        = st[s-1];
        k             = (st[s-1].month <= 4'd2);
        yk            = {2'd0, st[s-1].year} + YearOffset - 13'd2000 - {12'd0, k};
        nxt[s].term_a = 22'(({11'd0, yk} * 24'd1461) >> 2);
        nxt[s].term_b = month_term(st[s-1].month);
      end
    end else if (s == 2) begin : g_jdn
      always_comb begin
        nxt[s]     = st[s-1];
        nxt[s].jdn = {17'd0, st[s-1].day} + st[s-1].term_a
                   + {13'd0, st[s-1].term_b} - JdnBias;
        nxt[s].rem = {12'd0, st[s-1].prod[31:12]};
        nxt[s].low = {st[s-1].prod[11:0], 20'd0};
        nxt[s].quo = '0;
        nxt[s].ovf = ({12'd0, st[s-1].prod[31:12]} >= clock_count);
      end
    end else begin : g_div
      div_t din, dout;
      assign din = '{rem: st[s-1].rem, low: st[s-1].low, quo: st[s-1].quo};
      ptd_div_step u_step (
        .din     (din),
        .divisor (clock_count),
        .dout    (dout)
      );
      always_comb begin
        nxt[s]     = st[s-1];
        nxt[s].rem = dout.rem;
        nxt[s].low = dout.low;
        nxt[s].quo = dout.quo;
        if (s == DivFirst) begin
          nxt[s].secs = 39'({17'd0, st[s-1].jdn} * 39'd86400);
          nxt[s].hms  = 17'({12'd0, st[s-1].hour} * 17'd3600)
                      + 17'({11'd0, st[s-1].minute} * 17'd60)
                      + {11'd0, st[s-1].second};
        end else if (s == DivFirst + 1) begin
          nxt[s].secs = st[s-1].secs + {22'd0, st[s-1].hms};
        end
      end
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    for (int s = 0; s < NumStages; s++) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en[s]) begin
        vld[s] <= (s == 0) ? item_valid : vld[(s == 0) ? 0 : s - 1];
      end
      if (en[s]) st[s] <= nxt[s];
    end
  end

  // result beat
  assign result_valid      = vld[NumStages-1];
  assign year              = st[NumStages-1].year;
  assign month             = st[NumStages-1].month;
  assign day_of_month      = st[NumStages-1].day;
  assign hour_value        = st[NumStages-1].hour;
  assign minute_value      = st[NumStages-1].minute;
  assign second_value      = st[NumStages-1].second;
  assign julian_day_number = st[NumStages-1].jdn;
  assign absolute_seconds  = st[NumStages-1].secs;
  assign tick_count        = st[NumStages-1].ticks;
  assign fraction_us       = st[NumStages-1].ovf ? FracMax : st[NumStages-1].quo;
  assign channel_kind      = st[NumStages-1].kind;
  assign bad_digit         = st[NumStages-1].bad;

`ifndef SYNTH
  // divider remainder stays below the divisor when not saturated
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid && !st[NumStages-1].ovf |-> st[NumStages-1].rem < clock_count)
    else $error("divider remainder out of range");

  // zero clock count always saturates
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    result_valid && clock_count == 32'd0 |-> fraction_us == FracMax)
    else $error("zero clock count not saturated");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");
`endif

endmodule

>>> tb/packed_timestamp_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_timestamp_decoder_core_tb
// Self-checking bench for the timestamp decoder: a directed table, then random
// ASCII timestamps under several clock_count settings, with random gaps on
// the item side and random stalls on the result side.
// ----------------------------------------------------------------------------
module packed_timestamp_decoder_core_tb import ptd_pkg::*; ;

  localparam int RandPerPhase = 300;
  localparam int CycleLimit   = 600000;
  localparam int DrainCycles  = 40;

  // decoded timestamp as it leaves the block
  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_value;
    logic [5:0]  minute_value;
    logic [5:0]  second_value;
    logic [21:0] julian_day_number;
    logic [38:0] absolute_seconds;
    logic [11:0] tick_count;
    logic [31:0] fraction_us;
    logic        channel_kind;
    logic        bad_digit;
  } stamp_t;

  // directed row; typed fields are checked against known values
  typedef struct {
    logic [63:0] date;
    logic [23:0] tick;
    bit          known;
    logic        bad;
    logic [11:0] ticks;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [63:0] date_chars = '0;
  logic [23:0] tick_chars = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [10:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour_value;
  logic [5:0]  minute_value;
  logic [5:0]  second_value;
  logic [21:0] julian_day_number;
  logic [38:0] absolute_seconds;
  logic [11:0] tick_count;
  logic [31:0] fraction_us;
  logic        channel_kind;
  logic        bad_digit;

  stamp_t      pending_stamps[$];
  logic [31:0] clock_setting;
  int          fail_count = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          cycle_count = 0;
  bit          steady_mode = 1'b0;
  int          stall_left = 0;

  packed_timestamp_decoder_core i_dut (.*);

  always #5 clk = ~clk;

  // hex character to {not-hex flag, nibble}
  function automatic logic [4:0] char_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
    return 5'h10;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 10) return 8'("0" + v);
    return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  // decode one timestamp the way the block should
  function automatic stamp_t decode_stamp(input logic [63:0] d, input logic [23:0] t,
                                          input logic [31:0] cc);
    logic [3:0]       nib[8];
    logic [4:0]       nv;
    logic             bad;
    longint           yr, mo, dy, hr, mi, se, k, jdn, secs;
    longint unsigned  ticks, quo;
    stamp_t           r;
    bad = 1'b0;
    ticks = 0;
    for (int i = 0; i < 8; i++) begin
      nv = char_nibble(d[63 - 8*i -: 8]);
      bad |= nv[4];
      nib[i] = nv[3:0];
    end
    for (int i = 0; i < 3; i++) begin
      nv = char_nibble(t[23 - 8*i -: 8]);
      bad |= nv[4];
      ticks = (ticks << 4) | nv[3:0];
    end
    yr = ((nib[0] << 2) | (nib[1] >> 2)) & 'h0f;
    mo = ((nib[1] << 2) | (nib[2] >> 2)) & 'h0f;
    dy = ((nib[2] << 3) | (nib[3] >> 1)) & 'h1f;
    hr = ((nib[3] << 4) | nib[4]) & 'h1f;
    mi = ((nib[5] << 2) | (nib[6] >> 2)) & 'h3f;
    se = ((nib[6] << 4) | nib[7]) & 'h3f;
    yr += 2000;
    if (yr < 2009) yr += 16;
    // fliegel / van flandern, truncating division
    k = (14 - mo) / 12;
    jdn = dy - 32075 + 1461 * (yr + 4800 - k) / 4 + 367 * (mo - 2 + k * 12) / 12
          - 3 * ((yr + 4900 - k) / 100) / 4;
    jdn &= 'h3FFFFF;
    secs = jdn * 86400 + hr * 3600 + mi * 60 + se;
    if (cc == 0) quo = 64'hFFFF_FFFF;
    else begin
      quo = ticks * 64'd1048576 * 64'd1000000 / cc;
      if (quo > 64'hFFFF_FFFF) quo = 64'hFFFF_FFFF;
    end
    r.year = yr[10:0];
    r.month = mo[3:0];
    r.day_of_month = dy[4:0];
    r.hour_value = hr[4:0];
    r.minute_value = mi[5:0];
    r.second_value = se[5:0];
    r.julian_day_number = jdn[21:0];
    r.absolute_seconds = secs[38:0];
    r.tick_count = ticks[11:0];
    r.fraction_us = quo[31:0];
    r.channel_kind = nib[0][3];
    r.bad_digit = bad;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // result side: compare each beat, then draw the next stall run
  always @(posedge clk) begin
    stamp_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        beats_out++;
        if (pending_stamps.size() == 0) begin
          $display("%0t unexpected result beat, year %0d", $time, year);
          fail_count++;
        end else begin
          want = pending_stamps.pop_front();
          check_field("year", want.year, year);
          check_field("month", want.month, month);
          check_field("day_of_month", want.day_of_month, day_of_month);
          check_field("hour_value", want.hour_value, hour_value);
          check_field("minute_value", want.minute_value, minute_value);
          check_field("second_value", want.second_value, second_value);
          check_field("julian_day_number", want.julian_day_number, julian_day_number);
          check_field("absolute_seconds", want.absolute_seconds, absolute_seconds);
          check_field("tick_count", want.tick_count, tick_count);
          check_field("fraction_us", want.fraction_us, fraction_us);
          check_field("channel_kind", want.channel_kind, channel_kind);
          check_field("bad_digit", want.bad_digit, bad_digit);
        end
        stall_left = steady_mode ? 0 : $urandom_range(0, 19);
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // one item beat, with a random gap before it
  task automatic send_stamp(input logic [63:0] d, input logic [23:0] t, input bit known,
                            input logic bad, input logic [11:0] ticks);
    int     gap;
    stamp_t want;
    gap = steady_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    date_chars <= d;
    tick_chars <= t;
    do @(posedge clk); while (item_stall);
    want = decode_stamp(d, t, clock_setting);
    if (known) begin
      want.bad_digit = bad;
      want.tick_count = ticks;
    end
    pending_stamps.push_back(want);
    beats_in++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // apb write of clock_count, only with the pipeline empty
  task automatic write_clock_count(input logic [31:0] v);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * RegClockCount);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    clock_setting = v;
  endtask

  // random character: mostly hex of either case, sometimes any byte
  function automatic logic [7:0] rand_char(input bit noisy);
    if (noisy && $urandom_range(0, 5) == 0) return 8'($urandom);
    return hex_char(4'($urandom), 1'($urandom_range(0, 1)));
  endfunction

  row_t        directed[] = '{
    '{"00000000", "000", 1, 1'b0, 12'h000},
    '{"FFFFFFFF", "FFF", 1, 1'b0, 12'hFFF},
    '{"ffffffff", "fff", 1, 1'b0, 12'hFFF},
    '{"7FFFFFFF", "800", 1, 1'b0, 12'h800},
    '{"80000000", "001", 1, 1'b0, 12'h001},
    '{"G0000000", "000", 1, 1'b1, 12'h000},
    '{"0000000/", "000", 1, 1'b1, 12'h000},
    '{"00:00@00", "000", 1, 1'b1, 12'h000},
    '{"12345678", "g00", 1, 1'b1, 12'h000},
    '{"12345678", "9`F", 1, 1'b1, 12'h90F},
    '{{8{8'h00}}, {3{8'hFF}}, 1, 1'b1, 12'h000},
    '{{8{8'hFF}}, {3{8'h00}}, 1, 1'b1, 12'h000},
    '{"20000000", "123", 0, 1'b0, 12'h000},
    '{"24000000", "abc", 0, 1'b0, 12'h000},
    '{"23C00000", "ABC", 0, 1'b0, 12'h000},
    '{"23400000", "400", 0, 1'b0, 12'h000},
    '{"24bc8f7b", "9aF", 0, 1'b0, 12'h000},
    '{"3fff0000", "7Ff", 0, 1'b0, 12'h000},
    '{"0000fbbf", "010", 0, 1'b0, 12'h000},
    '{"a5a5a5a5", "5a5", 0, 1'b0, 12'h000}
  };

  logic [31:0] settings[] = '{32'd1048576, 32'hFFFF_FFFF, 32'd0, 32'd1000, 32'd0, 32'd4194304};

  initial begin
    logic [63:0] d;
    logic [23:0] t;
    bit          noisy;
    clock_setting = 32'd4194304;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at the reset value of clock_count
    foreach (directed[i])
      send_stamp(directed[i].date, directed[i].tick, directed[i].known,
                 directed[i].bad, directed[i].ticks);
    // hold the sender until the pipeline has emptied
    item_valid <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);

    foreach (settings[p]) begin
      if (p == 2) settings[p] = $urandom_range(32'd1048576, 32'hFFFF_FFFF);
      write_clock_count(settings[p]);
      steady_mode = (p == 3);
      repeat (RandPerPhase) begin
        noisy = ($urandom_range(0, 9) == 0);
        for (int c = 0; c < 8; c++) d[63 - 8*c -: 8] = rand_char(noisy);
        for (int c = 0; c < 3; c++) t[23 - 8*c -: 8] = rand_char(noisy);
        send_stamp(d, t, 0, 1'b0, 12'h000);
      end
      steady_mode = 1'b0;
    end

    wait_drained();
    $display("sent %0d timestamps, checked %0d results over %0d clock_count settings",
             beats_in, beats_out, settings.size() + 1);
    $display("settings included zero, small, minimum and maximum divisors");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
